>>> src/delimited_length_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver RTL.
// Needs no other file; the including module supplies clock and reset names.
`ifndef DELIMITED_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define DELIMITED_LENGTH_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DLFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver assertion failed");

// Next-cycle implication, disabled during reset.
`define DLFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver assertion failed");

`endif

>>> src/dlfr_pkg.sv
// Package for the delimited length frame receiver: parse phases, register
// indexes, reset codes and result kinds. Depends on nothing.
`default_nettype none

package dlfr_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LengthWidth = 16;
   localparam int unsigned CsrIdxWidth = 2;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [LengthWidth-1:0] length_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;

   // Register indexes of the configuration port.
   localparam csr_idx_type CSR_START_CODE = csr_idx_type'(0);
   localparam csr_idx_type CSR_END_CODE   = csr_idx_type'(1);

   // Reset values of the delimiter registers.
   localparam byte_type START_CODE_RESET = byte_type'(8'h02);
   localparam byte_type END_CODE_RESET   = byte_type'(8'h03);

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_CORRUPT = 1'b1;

   // Parse phases of the frame.
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LEN_LO  = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_END     = 3'd4
   } phase_type;

endpackage

`default_nettype wire

>>> src/delimited_length_frame_receiver.sv
// Delimited length frame receiver: one byte per clock from an input register,
// frame parse and result register. Depends on dlfr_pkg and the assert header.
//
// Takes one received byte per clock and passes on each payload byte of a
// frame (start byte, 16-bit little-endian length, payload, end byte), marked
// as first and last of its frame. Bytes outside a frame that are not the
// start byte are dropped. A wrong end byte gives one corruption result and
// closes the link until reset; all later bytes are taken and ignored. An item
// passes through the input register, then the result register, and a new
// byte is accepted every cycle; the only throttle is the result register,
// which stalls the input side while its result is stalled. The user must
// write delimiter registers through the csr port only while the block is
// idle; the block itself does not enforce it. csr_ready is always high.
`default_nettype none

`include "delimited_length_frame_receiver_assert.svh"

module delimited_length_frame_receiver (
   input  wire                      clock,
   input  wire                      reset,
   // Input byte channel.
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire  dlfr_pkg::byte_type req_rx_byte,
   // Result channel.
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic                     rsp_kind,
   output dlfr_pkg::byte_type       rsp_payload_byte,
   output logic                     rsp_first_of_frame,
   output logic                     rsp_last_of_frame,
   output logic                     rsp_link_closed,
   // Configuration write channel.
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  dlfr_pkg::csr_idx_type csr_index,
   input  wire  dlfr_pkg::byte_type csr_data
);
   import dlfr_pkg::*;

   // Configuration registers.
   byte_type   start_code_ff, start_code_in;
   byte_type   end_code_ff, end_code_in;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff, in_byte_in;

   // Parse state.
   phase_type  phase_ff, phase_in;
   length_type remaining_ff, remaining_in;
   byte_type   length_low_ff, length_low_in;
   logic       first_pending_ff, first_pending_in;
   logic       closed_ff, closed_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff, rsp_kind_in;
   byte_type   rsp_byte_ff, rsp_byte_in;
   logic       rsp_first_ff, rsp_first_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_closed_ff, rsp_closed_in;

   // Stage handshakes.
   logic       out_free;
   logic       proc_go;
   logic       req_fire;
   logic       res_valid;
   logic       res_kind;
   byte_type   res_byte;
   logic       res_first;
   logic       res_last;
   logic       pay_last;

   // The result register is free when empty or its transaction completes now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_go   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration writes; indexes beyond the list are ignored.
   always_comb begin
      start_code_in = start_code_ff;
      end_code_in   = end_code_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_CODE: start_code_in = csr_data;
            CSR_END_CODE:   end_code_in   = csr_data;
            default:        ;
         endcase
      end
   end

   // Input register loads on every accepted transaction.
   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (in_valid_ff && !proc_go);
      in_byte_in  = req_fire ? req_rx_byte : in_byte_ff;
   end

   assign pay_last = (remaining_ff <= length_type'(1));

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      if (proc_go && !closed_ff) begin
         unique case (phase_ff)
            PH_LEN_LO:  phase_in = PH_LEN_HI;
            PH_LEN_HI:  phase_in = ({in_byte_ff, length_low_ff} == '0) ? PH_END : PH_PAYLOAD;
            PH_PAYLOAD: phase_in = pay_last ? PH_END : PH_PAYLOAD;
            PH_END:     phase_in = PH_IDLE;
            default:    phase_in = (in_byte_ff == start_code_ff) ? PH_LEN_LO : PH_IDLE;
         endcase
      end
   end

   // Datapath state and result of the byte in the input register.
   always_comb begin
      remaining_in     = remaining_ff;
      length_low_in    = length_low_ff;
      first_pending_in = first_pending_ff;
      closed_in        = closed_ff;
      res_valid        = 1'b0;
      res_kind         = KIND_PAYLOAD;
      res_byte         = '0;
      res_first        = 1'b0;
      res_last         = 1'b0;
      if (proc_go && !closed_ff) begin
         unique case (phase_ff)
            PH_LEN_LO: begin
               length_low_in = in_byte_ff;
            end
            PH_LEN_HI: begin
               remaining_in     = {in_byte_ff, length_low_ff};
               first_pending_in = 1'b1;
            end
            PH_PAYLOAD: begin
               res_valid        = 1'b1;
               res_byte         = in_byte_ff;
               res_first        = first_pending_ff;
               res_last         = pay_last;
               first_pending_in = 1'b0;
               remaining_in     = pay_last ? '0 : remaining_ff - length_type'(1);
            end
            PH_END: begin
               if (in_byte_ff != end_code_ff) begin
                  closed_in        = 1'b1;
                  remaining_in     = '0;
                  first_pending_in = 1'b0;
                  res_valid        = 1'b1;
                  res_kind         = KIND_CORRUPT;
               end
            end
            default: ;
         endcase
      end
   end

   // Result register: load on a processed byte, otherwise hold while stalled.
   always_comb begin
      rsp_valid_in  = proc_go ? res_valid : (rsp_valid_ff && rsp_stall);
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_closed_in = rsp_closed_ff;
      if (proc_go && res_valid) begin
         rsp_kind_in   = res_kind;
         rsp_byte_in   = res_byte;
         rsp_first_in  = res_first;
         rsp_last_in   = res_last;
         rsp_closed_in = (res_kind == KIND_CORRUPT);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff    <= START_CODE_RESET;
         end_code_ff      <= END_CODE_RESET;
         in_valid_ff      <= 1'b0;
         phase_ff         <= PH_IDLE;
         remaining_ff     <= '0;
         length_low_ff    <= '0;
         first_pending_ff <= 1'b0;
         closed_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         start_code_ff    <= start_code_in;
         end_code_ff      <= end_code_in;
         in_valid_ff      <= in_valid_in;
         phase_ff         <= phase_in;
         remaining_ff     <= remaining_in;
         length_low_ff    <= length_low_in;
         first_pending_ff <= first_pending_in;
         closed_ff        <= closed_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_closed_ff <= rsp_closed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_first_of_frame = rsp_first_ff;
   assign rsp_last_of_frame  = rsp_last_ff;
   assign rsp_link_closed    = rsp_closed_ff;

   // A closed link stays closed until reset.
   `DLFR_ASSERT_NEXT(a_closed_sticky, clock, reset, closed_ff, closed_ff)
   // Once closed, no byte produces a result.
   `DLFR_ASSERT_SAME(a_no_result_closed, clock, reset, closed_ff, !res_valid)
   // A corruption result carries the closed flag and no payload.
   `DLFR_ASSERT_SAME(a_corrupt_shape, clock, reset, rsp_valid_ff && rsp_kind_ff,
      rsp_closed_ff && (rsp_byte_ff == '0) && !rsp_first_ff && !rsp_last_ff)
   // A result taken from the payload phase never reports the link closed.
   `DLFR_ASSERT_SAME(a_payload_open, clock, reset, rsp_valid_ff && !rsp_kind_ff,
      !rsp_closed_ff)
   // Entering the end check always leaves no payload bytes outstanding.
   `DLFR_ASSERT_SAME(a_end_no_remaining, clock, reset,
      (phase_ff == PH_END) && !closed_ff, remaining_ff == '0)

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the delimited length frame receiver.
// Depends on dlfr_pkg and the receiver RTL; it predicts each result from the
// accepted byte stream and checks every result transaction against it.

module tb;
   import dlfr_pkg::*;

   // Register indexes past the end of the register list; writes are ignored.
   localparam csr_idx_type CSR_UNUSED_LO = csr_idx_type'(2);
   localparam csr_idx_type CSR_UNUSED_HI = csr_idx_type'(3);

   // Cycles for the input and result registers to empty after the last byte.
   localparam int unsigned PIPE_SETTLE    = 4;
   localparam int unsigned END_SETTLE     = 8;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned PHASE_BYTES    = 320;

   typedef struct packed {
      logic     kind;
      byte_type data;
      logic     first;
      logic     last;
      logic     closed;
   } frame_result_type;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   byte_type    req_rx_byte = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   byte_type    rsp_payload_byte;
   logic        rsp_first_of_frame;
   logic        rsp_last_of_frame;
   logic        rsp_link_closed;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = '0;
   byte_type    csr_data = '0;

   // Byte stream waiting to be sent and results still owed by the block.
   byte_type         rx_stream[$];
   frame_result_type frame_results_due[$];

   // Deframer prediction state and its delimiter settings.
   phase_type  parse_phase  = PH_IDLE;
   length_type bytes_left   = '0;
   byte_type   len_low_hold = '0;
   logic       first_due    = 1'b0;
   logic       link_dead    = 1'b0;
   byte_type   cfg_start    = START_CODE_RESET;
   byte_type   cfg_end      = END_CODE_RESET;

   int unsigned gap_left       = 0;
   int unsigned stall_left     = 0;
   int unsigned idle_cycles    = 0;
   int unsigned mismatch_count = 0;
   logic        quiet_tail     = 1'b0;

   delimited_length_frame_receiver uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_first_of_frame (rsp_first_of_frame),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_link_closed    (rsp_link_closed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the deframer by one accepted byte and record any result it owes.
   function automatic void deframe_byte(input byte_type b);
      frame_result_type r;
      r = '0;
      if (link_dead) return;
      case (parse_phase)
         PH_LEN_LO: begin
            len_low_hold = b;
            parse_phase  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            bytes_left  = {b, len_low_hold};
            first_due   = 1'b1;
            parse_phase = (bytes_left == '0) ? PH_END : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            r.kind     = KIND_PAYLOAD;
            r.data     = b;
            r.first    = first_due;
            r.last     = (bytes_left <= length_type'(1));
            first_due  = 1'b0;
            bytes_left = bytes_left - length_type'(1);
            if (r.last) begin
               bytes_left  = '0;
               parse_phase = PH_END;
            end
            frame_results_due.push_back(r);
         end
         PH_END: begin
            if (b == cfg_end) begin
               parse_phase = PH_IDLE;
            end else begin
               // A bad closing byte reports once and shuts the link for good.
               link_dead   = 1'b1;
               parse_phase = PH_IDLE;
               bytes_left  = '0;
               first_due   = 1'b0;
               r.kind      = KIND_CORRUPT;
               r.closed    = 1'b1;
               frame_results_due.push_back(r);
            end
         end
         default: begin
            parse_phase = (b == cfg_start) ? PH_LEN_LO : PH_IDLE;
         end
      endcase
   endfunction

   // Queue one well-formed frame around the given payload.
   function automatic void queue_frame(input byte_type body[$]);
      length_type len;
      len = length_type'(body.size());
      rx_stream.push_back(cfg_start);
      rx_stream.push_back(len[7:0]);
      rx_stream.push_back(len[15:8]);
      foreach (body[i]) rx_stream.push_back(body[i]);
      rx_stream.push_back(cfg_end);
   endfunction

   // Queue frames with random payloads mixed with stray bytes between frames.
   task automatic queue_random_traffic(input int unsigned budget, input bit with_long);
      byte_type    body[$];
      byte_type    b;
      int unsigned count;
      int unsigned len;
      int unsigned pick;
      count = 0;
      while (count < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            // Stray bytes are anything but the start code.
            repeat ($urandom_range(1, 4)) begin
               do b = byte_type'($urandom); while (b == cfg_start);
               rx_stream.push_back(b);
               count++;
            end
         end else begin
            if (with_long) begin
               len = $urandom_range(256, 300);
               with_long = 1'b0;
            end else if (pick < 75) begin
               len = $urandom_range(0, 6);
            end else begin
               len = $urandom_range(7, 40);
            end
            body = {};
            repeat (len) body.push_back(byte_type'($urandom));
            queue_frame(body);
            count += len + 4;
         end
      end
   endtask

   // Wait until every byte has been taken and every result has come back.
   task automatic wait_drained();
      do @(posedge clock);
      while (rx_stream.size() != 0 || req_valid || frame_results_due.size() != 0);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // One register write transaction; the predictor follows on acceptance.
   task automatic write_csr(input csr_idx_type idx, input byte_type val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_START_CODE) cfg_start = val;
      else if (idx == CSR_END_CODE) cfg_end = val;
   endtask

   // Byte driver: presents queued bytes, holds while stalled, idles in bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_stream.size() > 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_stream.pop_front();
               if (!quiet_tail && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each result transaction and stalls in bursts.
   always @(posedge clock) begin : result_check
      frame_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_results_due.size() == 0) begin
               $error("result transaction arrived with none expected");
               mismatch_count++;
            end else begin
               want = frame_results_due.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
                  mismatch_count++;
               end
               if (rsp_payload_byte !== want.data) begin
                  $error("payload_byte: expected %0h, actual %0h", want.data, rsp_payload_byte);
                  mismatch_count++;
               end
               if (rsp_first_of_frame !== want.first) begin
                  $error("first_of_frame: expected %0d, actual %0d",
                         want.first, rsp_first_of_frame);
                  mismatch_count++;
               end
               if (rsp_last_of_frame !== want.last) begin
                  $error("last_of_frame: expected %0d, actual %0d",
                         want.last, rsp_last_of_frame);
                  mismatch_count++;
               end
               if (rsp_link_closed !== want.closed) begin
                  $error("link_closed: expected %0d, actual %0d", want.closed, rsp_link_closed);
                  mismatch_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet_tail && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 8);
         end
      end
   end

   // Watchdog: ends the run when no transaction of any kind makes progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus sequence: directed cases, random phases per delimiter setting,
   // then a quiet tail in which a corrupted frame closes the link.
   initial begin : stimulus
      byte_type body[$];
      byte_type codes_start[5];
      byte_type codes_end[5];

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset delimiters: stray bytes, a one-byte frame, an empty frame and a
      // frame whose payload carries both delimiter values.
      rx_stream.push_back(8'h00);
      rx_stream.push_back(8'hFF);
      rx_stream.push_back(END_CODE_RESET);
      body = {8'hFF};
      queue_frame(body);
      body = {};
      queue_frame(body);
      body = {START_CODE_RESET, END_CODE_RESET};
      queue_frame(body);
      wait_drained();

      // Writes past the register list must leave the delimiters alone.
      write_csr(CSR_UNUSED_LO, 8'h55);
      write_csr(CSR_UNUSED_HI, 8'hAA);
      body = {8'h80};
      queue_frame(body);

      codes_start = '{8'h00, 8'hFF, byte_type'($urandom), 8'h7E, START_CODE_RESET};
      codes_end   = '{8'hFF, 8'h00, byte_type'($urandom), 8'h7E, END_CODE_RESET};
      for (int p = 0; p < 5; p++) begin
         wait_drained();
         write_csr(CSR_START_CODE, codes_start[p]);
         write_csr(CSR_END_CODE, codes_end[p]);
         if (p == 1) begin
            // Hold the sender halfway until every owed result has come back.
            queue_random_traffic(PHASE_BYTES / 2, 1'b0);
            wait_drained();
            queue_random_traffic(PHASE_BYTES / 2, 1'b0);
         end else begin
            queue_random_traffic(PHASE_BYTES, p == 2);
         end
      end

      // Quiet tail: clean frames, then a bad closing byte closes the link and
      // everything after it, including a good frame, is ignored. Idle bursts
      // already under way run out before the tail starts.
      quiet_tail = 1'b1;
      wait_drained();
      repeat (END_SETTLE) @(posedge clock);
      queue_random_traffic(40, 1'b0);
      body = {byte_type'($urandom), byte_type'($urandom)};
      rx_stream.push_back(cfg_start);
      rx_stream.push_back(8'h02);
      rx_stream.push_back(8'h00);
      foreach (body[i]) rx_stream.push_back(body[i]);
      rx_stream.push_back(cfg_end ^ 8'h01);
      body = {8'h41};
      queue_frame(body);
      repeat (6) rx_stream.push_back(byte_type'($urandom));

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && frame_results_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
